### src/ray_triangle_intersect_defines.svh
// Assertion macros shared by the ray/triangle intersection RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RTI_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("rti: forbidden condition seen");
`define RTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("rti: expected follow-up missing");
`else
`define RTI_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define RTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection block.
// No dependencies.
package rti_pkg;

	localparam int MAX_TRIANGLES_DEF = 256;
	localparam int COORD_BITS_DEF    = 32;
	localparam int QUEUE_DEPTH       = 4;
	localparam int OUT_DEPTH         = 2;
	localparam int QUO_BITS          = 31;
	localparam int FRAC_BITS         = 16;

	localparam logic CMD_LOAD      = 1'b0;
	localparam logic CMD_INTERSECT = 1'b1;

	localparam logic REG_DET_EPSILON  = 1'b0;
	localparam logic REG_MIN_DISTANCE = 1'b1;

	localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic               cmd;
		logic [7:0]         tri_index;
		logic [1:0]         corner;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} item_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] distance;
		logic [7:0]  which_triangle;
	} result_t;

	typedef struct packed {
		logic [15:0] det_epsilon;
		logic [15:0] min_distance;
	} cfg_t;

endpackage

### src/rti_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/rti_fifo.sv
// Small register FIFO used for the front/back queue and the result queue.
// No dependencies.
module rti_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW   = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == CNTW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNTW'(do_push) - CNTW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

### src/rti_front.sv
// Front end: takes requests, writes corner loads into the vertex RAMs and
// reads the three corners for intersect requests. Uses rti_pkg, rti_ram.
module rti_front #(
	parameter int MAX_TRIANGLES = rti_pkg::MAX_TRIANGLES_DEF,
	parameter int COORD_BITS    = rti_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rti_pkg::item_t               item,
	input  logic                         push,
	output logic                         full,
	output logic                         qpush,
	output logic [9+15*COORD_BITS-1:0]   qdata,
	input  logic                         qfull
);

	localparam int W  = COORD_BITS;
	localparam int AW = MAX_TRIANGLES > 1 ? $clog2(MAX_TRIANGLES) : 1;

	logic                accept;
	logic                is_int;
	logic                oor;
	logic [AW-1:0]       addr;
	logic signed [W-1:0] cin [3];
	logic signed [W-1:0] din [3];
	logic signed [W-1:0] vr  [3][3];

	logic                vld_s1;
	logic [7:0]          tri_s1;
	logic                oor_s1;
	logic signed [W-1:0] o_s1 [3];
	logic signed [W-1:0] d_s1 [3];

	assign is_int = item.cmd == rti_pkg::CMD_INTERSECT;
	assign full   = vld_s1 && qfull;
	assign accept = push && !full;
	assign oor    = int'(item.tri_index) >= MAX_TRIANGLES;
	assign addr   = AW'(item.tri_index);

	assign cin[0] = W'(item.px);
	assign cin[1] = W'(item.py);
	assign cin[2] = W'(item.pz);
	assign din[0] = W'(item.dir_x);
	assign din[1] = W'(item.dir_y);
	assign din[2] = W'(item.dir_z);

	// one RAM per corner and axis: all three corners come out in one read
	for (genvar c = 0; c < 3; c++) begin : g_corner
		for (genvar a = 0; a < 3; a++) begin : g_axis
			rti_ram #(
				.WIDTH(W),
				.DEPTH(MAX_TRIANGLES)
			) u_ram (
				.clk  (clk),
				.we   (accept && !is_int && item.corner == 2'(c) && !oor),
				.waddr(addr),
				.wdata(cin[a]),
				.re   (accept && is_int),
				.raddr(addr),
				.rdata(vr[c][a])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!full) begin
			vld_s1 <= accept && is_int;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_int) begin
			tri_s1 <= item.tri_index;
			oor_s1 <= oor;
			for (int k = 0; k < 3; k++) begin
				o_s1[k] <= cin[k];
				d_s1[k] <= din[k];
			end
		end
	end

	assign qpush = vld_s1;
	assign qdata = {tri_s1, oor_s1, o_s1[0], o_s1[1], o_s1[2], d_s1[0], d_s1[1], d_s1[2],
		vr[0][0], vr[0][1], vr[0][2], vr[1][0], vr[1][1], vr[1][2],
		vr[2][0], vr[2][1], vr[2][2]};

endmodule

### src/rti_back.sv
// Back end: Moller-Trumbore arithmetic pipeline and restoring divider for t.
// Uses rti_pkg.
module rti_back #(
	parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rti_pkg::cfg_t              cfg,
	input  logic [9+15*COORD_BITS-1:0] qdata,
	input  logic                       qempty,
	output logic                       qpop,
	output rti_pkg::result_t           rsp,
	output logic                       opush,
	input  logic                       ofull
);

	localparam int W   = COORD_BITS;
	localparam int EW  = W + 1;
	localparam int CW  = 2 * EW + 1;
	localparam int SPL = CW / 2;
	localparam int HW  = CW - SPL;
	localparam int LW  = EW + SPL + 1;
	localparam int UW  = EW + HW;
	localparam int DW  = 3 * EW + 3;
	localparam int QB  = rti_pkg::QUO_BITS;
	localparam int RW  = DW + QB;

	typedef struct packed {
		logic [7:0] tri_index;
		logic       oor;
	} ctl_t;

	logic                adv;
	ctl_t                ctl_in;
	logic signed [W-1:0] o_in [3];
	logic signed [W-1:0] d_in [3];
	logic signed [W-1:0] v0 [3];
	logic signed [W-1:0] v1 [3];
	logic signed [W-1:0] v2 [3];

	assign {ctl_in, o_in[0], o_in[1], o_in[2], d_in[0], d_in[1], d_in[2],
		v0[0], v0[1], v0[2], v1[0], v1[1], v1[2], v2[0], v2[1], v2[2]} = qdata;

	// whole pipeline moves together; it holds only when the result queue is full
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8 [QB];

	assign adv   = !(vld_s8[QB-1] && ofull);
	assign qpop  = adv && !qempty;
	assign opush = vld_s8[QB-1] && !ofull;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3], d_s1 [3];
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], s_s2 [3], d_s2 [3];
	logic signed [EW-1:0] e1_s3 [3], e2_s3 [3], s_s3 [3], d_s3 [3];
	logic signed [2*EW-1:0] hp_s2 [3][2];
	logic signed [2*EW-1:0] qp_s2 [3][2];
	logic signed [CW-1:0] h_s3 [3];
	logic signed [CW-1:0] q_s3 [3];
	logic signed [EW-1:0] av [4][3];
	logic signed [CW-1:0] cv [4][3];
	logic signed [LW-1:0] lo_s4 [4][3];
	logic signed [UW-1:0] hi_s4 [4][3];
	logic signed [DW-1:0] term_s5 [4][3];
	logic signed [DW-1:0] dot_s6 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= !qempty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// s1: edges and origin offset
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_in;
			for (int k = 0; k < 3; k++) begin
				e1_s1[k] <= EW'(v1[k]) - EW'(v0[k]);
				e2_s1[k] <= EW'(v2[k]) - EW'(v0[k]);
				s_s1[k]  <= EW'(o_in[k]) - EW'(v0[k]);
				d_s1[k]  <= EW'(d_in[k]);
			end
		end
	end

	// s2: cross product terms, h = d x e2, q = s x e1
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_s1;
			for (int k = 0; k < 3; k++) begin
				hp_s2[k][0] <= d_s1[(k+1)%3] * e2_s1[(k+2)%3];
				hp_s2[k][1] <= d_s1[(k+2)%3] * e2_s1[(k+1)%3];
				qp_s2[k][0] <= s_s1[(k+1)%3] * e1_s1[(k+2)%3];
				qp_s2[k][1] <= s_s1[(k+2)%3] * e1_s1[(k+1)%3];
				e1_s2[k] <= e1_s1[k];
				e2_s2[k] <= e2_s1[k];
				s_s2[k]  <= s_s1[k];
				d_s2[k]  <= d_s1[k];
			end
		end
	end

	// s3: cross products
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3 <= ctl_s2;
			for (int k = 0; k < 3; k++) begin
				h_s3[k]  <= CW'(hp_s2[k][0]) - CW'(hp_s2[k][1]);
				q_s3[k]  <= CW'(qp_s2[k][0]) - CW'(qp_s2[k][1]);
				e1_s3[k] <= e1_s2[k];
				e2_s3[k] <= e2_s2[k];
				s_s3[k]  <= s_s2[k];
				d_s3[k]  <= d_s2[k];
			end
		end
	end

	// dot operands: det = e1.h, un = s.h, vn = d.q, tn = e2.q
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			av[0][k] = e1_s3[k];
			av[1][k] = s_s3[k];
			av[2][k] = d_s3[k];
			av[3][k] = e2_s3[k];
			cv[0][k] = h_s3[k];
			cv[1][k] = h_s3[k];
			cv[2][k] = q_s3[k];
			cv[3][k] = q_s3[k];
		end
	end

	// s4: each wide product split into low (unsigned) and high (signed) halves
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_s3;
			for (int g = 0; g < 4; g++) begin
				for (int k = 0; k < 3; k++) begin
					lo_s4[g][k] <= av[g][k] * $signed({1'b0, cv[g][k][SPL-1:0]});
					hi_s4[g][k] <= av[g][k] * $signed(cv[g][k][CW-1:SPL]);
				end
			end
		end
	end

	// s5: recombine halves
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5 <= ctl_s4;
			for (int g = 0; g < 4; g++) begin
				for (int k = 0; k < 3; k++) begin
					term_s5[g][k] <= (DW'(hi_s4[g][k]) <<< SPL) + DW'(lo_s4[g][k]);
				end
			end
		end
	end

	// s6: dot sums
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s6 <= ctl_s5;
			for (int g = 0; g < 4; g++) begin
				dot_s6[g] <= term_s5[g][0] + term_s5[g][1] + term_s5[g][2];
			end
		end
	end

	// s7: reject tests and divider setup
	logic signed [DW-1:0] eps_w;
	logic signed [DW:0]   uv_sum;
	logic                 miss_c;
	logic                 sat_c;
	logic                 miss_s7;
	logic                 sat_s7;
	logic [RW-1:0]        rem_s7;
	logic [DW-1:0]        det_s7;
	logic [7:0]           tri_s7;

	assign eps_w  = DW'({cfg.det_epsilon, 32'd0});
	assign uv_sum = (DW+1)'(dot_s6[1]) + (DW+1)'(dot_s6[2]);
	assign miss_c = ctl_s6.oor || dot_s6[0] == '0 || dot_s6[0] < eps_w
		|| dot_s6[1] < 0 || dot_s6[0] < dot_s6[1]
		|| dot_s6[2] < 0 || (DW+1)'(dot_s6[0]) < uv_sum
		|| dot_s6[3] < 0;
	// t would not fit in 31 bits
	assign sat_c  = $signed(RW'(dot_s6[3])) >= ($signed(RW'(dot_s6[0])) <<< (QB - rti_pkg::FRAC_BITS));

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s7 <= miss_c;
			sat_s7  <= sat_c;
			rem_s7  <= RW'(dot_s6[3]) << rti_pkg::FRAC_BITS;
			det_s7  <= dot_s6[0];
			tri_s7  <= ctl_s6.tri_index;
		end
	end

	// s8: restoring divider, one quotient bit per stage, MSB first
	logic [RW-1:0] rem_s8  [QB];
	logic [DW-1:0] det_s8  [QB];
	logic [QB-1:0] quo_s8  [QB];
	logic          miss_s8 [QB];
	logic          sat_s8  [QB];
	logic [7:0]    tri_s8  [QB];

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int K = QB - 1 - j;
		logic [RW-1:0] rin;
		logic [DW-1:0] din;
		logic [QB-1:0] qin;
		logic          vin, min, sin;
		logic [7:0]    tin;
		logic [RW-1:0] dk;
		logic          ge;

		if (j == 0) begin : g_first
			assign rin = rem_s7;
			assign din = det_s7;
			assign qin = '0;
			assign vin = vld_s7;
			assign min = miss_s7;
			assign sin = sat_s7;
			assign tin = tri_s7;
		end else begin : g_next
			assign rin = rem_s8[j-1];
			assign din = det_s8[j-1];
			assign qin = quo_s8[j-1];
			assign vin = vld_s8[j-1];
			assign min = miss_s8[j-1];
			assign sin = sat_s8[j-1];
			assign tin = tri_s8[j-1];
		end

		assign dk = RW'(din) << K;
		assign ge = rin >= dk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s8[j] <= 1'b0;
			end else if (adv) begin
				vld_s8[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s8[j]  <= ge ? rin - dk : rin;
				quo_s8[j]  <= qin | (ge ? (QB'(1) << K) : '0);
				det_s8[j]  <= din;
				miss_s8[j] <= min;
				sat_s8[j]  <= sin;
				tri_s8[j]  <= tin;
			end
		end
	end

	logic [QB-1:0] t_fin;
	logic          hit_fin;

	assign t_fin   = sat_s8[QB-1] ? rti_pkg::DIST_MAX : quo_s8[QB-1];
	assign hit_fin = !miss_s8[QB-1] && t_fin >= QB'(cfg.min_distance);

	assign rsp.hit            = hit_fin;
	assign rsp.distance       = hit_fin ? t_fin : rti_pkg::DIST_MAX;
	assign rsp.which_triangle = tri_s8[QB-1];

endmodule

### src/ray_triangle_intersect.sv
// Top level of the ray/triangle intersection block: config registers, queues,
// front and back ends. Uses rti_pkg, rti_front, rti_back, rti_fifo and the defines header.
//
// Usage:
//  - Requests enter through push/full as rti_pkg::item_t. cmd LOAD writes one
//    corner of one triangle slot and gives no result; cmd INTERSECT tests a
//    ray against a slot and gives exactly one result.
//  - Results leave through empty/pop as rti_pkg::result_t, oldest first.
//  - One request per cycle is sustained; the divider and multiplier pipeline
//    is fully pipelined, so the rate is set only by the handshakes.
//  - Path of a request: vertex RAM read on the accepting edge, then a
//    middle queue slot, 7 arithmetic stages, 31 divider stages and a
//    result queue write.
//  - When pop stays low the result queue fills, the back pipeline freezes,
//    the 4-entry middle queue fills, and then full rises.
//  - Reset clears control state and sets det_epsilon and min_distance to 1.
//    Vertex RAM contents are undefined until loaded; no clearing pass.
//  - Registers over APB: det_epsilon at 0x0, min_distance at 0x4. Write
//    only while no intersect is in flight.
`include "ray_triangle_intersect_defines.svh"

module ray_triangle_intersect #(
	parameter int MAX_TRIANGLES = rti_pkg::MAX_TRIANGLES_DEF,
	parameter int COORD_BITS    = rti_pkg::COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rti_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output rti_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int QW = 9 + 15 * COORD_BITS;

	// config registers
	rti_pkg::cfg_t cfg_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.det_epsilon  <= 16'd1;
			cfg_q.min_distance <= 16'd1;
		end else if (cfg_wr) begin
			if (paddr[2] == rti_pkg::REG_DET_EPSILON) begin
				cfg_q.det_epsilon <= pwdata[15:0];
			end else begin
				cfg_q.min_distance <= pwdata[15:0];
			end
		end
	end

	assign prdata = {16'd0, (paddr[2] == rti_pkg::REG_DET_EPSILON) ?
		cfg_q.det_epsilon : cfg_q.min_distance};

	// front end -> middle queue -> back end -> result queue
	logic          q_push, q_full, q_pop, q_empty;
	logic [QW-1:0] q_wdata, q_rdata;
	logic          o_push, o_full;
	rti_pkg::result_t o_wdata;
	logic [$bits(rti_pkg::result_t)-1:0] o_rdata;

	rti_front #(
		.MAX_TRIANGLES(MAX_TRIANGLES),
		.COORD_BITS   (COORD_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.push  (push),
		.full  (full),
		.qpush (q_push),
		.qdata (q_wdata),
		.qfull (q_full)
	);

	rti_fifo #(
		.WIDTH(QW),
		.DEPTH(rti_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	rti_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.qdata (q_rdata),
		.qempty(q_empty),
		.qpop  (q_pop),
		.rsp   (o_wdata),
		.opush (o_push),
		.ofull (o_full)
	);

	rti_fifo #(
		.WIDTH($bits(rti_pkg::result_t)),
		.DEPTH(rti_pkg::OUT_DEPTH)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (o_push),
		.wdata (o_wdata),
		.full  (o_full),
		.pop   (pop),
		.rdata (o_rdata),
		.empty (empty)
	);

	assign result = o_rdata;

	// a waiting result stays until it is popped
	`RTI_ASSERT_NEXT(a_result_hold, clk, arst_n, !empty && !pop, !empty)
	// back never takes from an empty queue
	`RTI_ASSERT_NEVER(a_queue_underrun, clk, arst_n, q_pop && q_empty)
	// pipeline freezes rather than dropping a result
	`RTI_ASSERT_NEVER(a_result_drop, clk, arst_n, o_push && o_full)
	// a stalled front request is still waiting on the next cycle
	`RTI_ASSERT_NEXT(a_front_hold, clk, arst_n, q_push && q_full, q_push)

endmodule
